/* rtl/gpio_pkg.sv */
`timescale 1ns / 1ps

package gpio_pkg;

    localparam int PinCountDefault = 32;
    localparam int WordWidth       = 32;
    localparam int ModeLanes       = 16;   // pins per mode word

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    // register map
    typedef enum logic [2:0] {
        REG_DATA      = 3'd0,
        REG_DIRECTION = 3'd1,
        REG_MODE_LOW  = 3'd2,
        REG_MODE_HIGH = 3'd3,
        REG_MASK      = 3'd4,
        REG_STATUS    = 3'd5,
        REG_BOTH_EDGE = 3'd6
    } reg_index_t;

    // per-pin interrupt mode codes
    localparam logic [1:0] MODE_LOW_LEVEL  = 2'd0;
    localparam logic [1:0] MODE_HIGH_LEVEL = 2'd1;
    localparam logic [1:0] MODE_RISING     = 2'd2;
    localparam logic [1:0] MODE_FALLING    = 2'd3;

    // interrupt configuration seen by the detector
    typedef struct packed {
        logic [WordWidth-1:0] mode_low;
        logic [WordWidth-1:0] mode_high;
        logic [WordWidth-1:0] both_edge;
    } irq_cfg_t;

endpackage

/* rtl/gpio_detect.sv */
`timescale 1ns / 1ps

module gpio_detect #(
    parameter int PIN_COUNT = gpio_pkg::PinCountDefault
) (
    input  gpio_pkg::irq_cfg_t               cfg,
    input  logic [gpio_pkg::WordWidth-1:0]   levels,
    input  logic [gpio_pkg::WordWidth-1:0]   prev_levels,
    output logic [gpio_pkg::WordWidth-1:0]   hits
);
    import gpio_pkg::*;

    logic [WordWidth-1:0] rise;
    logic [WordWidth-1:0] fall;

    assign rise = levels & ~prev_levels;
    assign fall = ~levels & prev_levels;

    for (genvar p = 0; p < WordWidth; p++) begin : g_pin
        if (p < PIN_COUNT) begin : g_used
            logic [1:0] mode;
            if (p < ModeLanes) begin : g_lo
                assign mode = cfg.mode_low[2*p +: 2];
            end
            else begin : g_hi
                assign mode = cfg.mode_high[2*(p-ModeLanes) +: 2];
            end

            always_comb
            begin
                if (cfg.both_edge[p])
                begin
                    hits[p] = rise[p] | fall[p];
                end
                else
                begin
                    case (mode)
                        MODE_LOW_LEVEL:  hits[p] = ~levels[p];
                        MODE_HIGH_LEVEL: hits[p] = levels[p];
                        MODE_RISING:     hits[p] = rise[p];
                        default:         hits[p] = fall[p];
                    endcase
                end
            end
        end
        else begin : g_unused
            assign hits[p] = 1'b0;
        end
    end

endmodule

/* rtl/gpio_port_with_interrupt_detect_unit.sv */
`timescale 1ns / 1ps

// channel  | dir | handshake            | tdata (low bit up)                  | tuser
// ---------+-----+----------------------+-------------------------------------+----------------
// s_axis   | in  | tvalid/tready        | write_data[31:0], pin_levels[63:32] | req_type[1:0],
//          |     |                      |                                     | reg_index[4:2]
// m_axis   | out | tvalid/tready        | read_data, pin_out, pin_drive_enable,| -
//          |     |                      | irq, zero pad to 104 bits           |
//
// one word per clock in steady state while m_axis_tready stays high; each word passes
// the input register, then register file update and result register together
// reset clears the port registers, the valid flags and the previous-level history
// a stalled result holds in the output register while the input register
// still takes one more word; tready upstream then drops until the result moves
// words execute strictly in arrival order, so reads see all earlier writes

module gpio_port_with_interrupt_detect_unit #(
    parameter int PIN_COUNT = gpio_pkg::PinCountDefault
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // write_data, pin_levels
    input  logic [4:0]   s_axis_tuser,   // req_type, reg_index

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // read_data, pin_out, pin_drive_enable, irq
);
    import gpio_pkg::*;

    // bits of real pins
    localparam logic [WordWidth-1:0] PinMask =
        WordWidth'((64'd1 << PIN_COUNT) - 64'd1);

    // input stage
    logic                 in_valid_reg;
    logic [63:0]          in_data_reg;
    logic [4:0]           in_user_reg;

    // port registers
    logic [WordWidth-1:0] data_reg,      data_next;
    logic [WordWidth-1:0] dir_reg,       dir_next;
    logic [WordWidth-1:0] mode_low_reg,  mode_low_next;
    logic [WordWidth-1:0] mode_high_reg, mode_high_next;
    logic [WordWidth-1:0] mask_reg,      mask_next;
    logic [WordWidth-1:0] status_reg,    status_next;
    logic [WordWidth-1:0] both_reg,      both_next;
    logic [WordWidth-1:0] prev_reg,      prev_next;

    // result stage
    logic                 out_valid_reg;
    logic [WordWidth-1:0] out_rdata_reg, rdata_next;
    logic [WordWidth-1:0] out_pin_reg;
    logic [WordWidth-1:0] out_oe_reg;
    logic                 out_irq_reg;

    logic                 advance;
    req_t                 req;
    reg_index_t           idx;
    logic [WordWidth-1:0] wdata;
    logic [WordWidth-1:0] levels;
    logic [WordWidth-1:0] hits;
    irq_cfg_t             irq_cfg;

    // the word in the input register executes when the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign req    = req_t'(in_user_reg[1:0]);
    assign idx    = reg_index_t'(in_user_reg[4:2]);
    assign wdata  = in_data_reg[31:0];
    assign levels = in_data_reg[63:32] & PinMask;

    assign irq_cfg.mode_low  = mode_low_reg;
    assign irq_cfg.mode_high = mode_high_reg;
    assign irq_cfg.both_edge = both_reg;

    gpio_detect #(
        .PIN_COUNT (PIN_COUNT)
    ) u_detect (
        .cfg         (irq_cfg),
        .levels      (levels),
        .prev_levels (prev_reg),
        .hits        (hits)
    );

    // register file update and read mux
    always_comb
    begin
        data_next      = data_reg;
        dir_next       = dir_reg;
        mode_low_next  = mode_low_reg;
        mode_high_next = mode_high_reg;
        mask_next      = mask_reg;
        status_next    = status_reg;
        both_next      = both_reg;
        prev_next      = prev_reg;
        rdata_next     = '0;

        unique case (req)
            REQ_READ:
            begin
                unique case (idx)
                    // output pins read back the data register, inputs the pads
                    REG_DATA:      rdata_next = (data_reg & dir_reg) | (levels & ~dir_reg);
                    REG_DIRECTION: rdata_next = dir_reg;
                    REG_MODE_LOW:  rdata_next = mode_low_reg;
                    REG_MODE_HIGH: rdata_next = mode_high_reg;
                    REG_MASK:      rdata_next = mask_reg;
                    REG_STATUS:    rdata_next = status_reg;
                    REG_BOTH_EDGE: rdata_next = both_reg;
                    default:       rdata_next = '0;
                endcase
            end
            REQ_WRITE:
            begin
                unique case (idx)
                    REG_DATA:      data_next      = wdata & PinMask;
                    REG_DIRECTION: dir_next       = wdata & PinMask;
                    REG_MODE_LOW:  mode_low_next  = wdata;
                    REG_MODE_HIGH: mode_high_next = wdata;
                    REG_MASK:      mask_next      = wdata & PinMask;
                    REG_STATUS:    status_next    = status_reg & ~wdata;  // write 1 to clear
                    REG_BOTH_EDGE: both_next      = wdata & PinMask;
                    default:       ;
                endcase
            end
            REQ_TICK:
            begin
                status_next = (status_reg | hits) & PinMask;
                prev_next   = levels;
            end
            default: ;
        endcase
    end

    // control and port registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            data_reg      <= '0;
            dir_reg       <= '0;
            mode_low_reg  <= '0;
            mode_high_reg <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            both_reg      <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                data_reg      <= data_next;
                dir_reg       <= dir_next;
                mode_low_reg  <= mode_low_next;
                mode_high_reg <= mode_high_next;
                mask_reg      <= mask_next;
                status_reg    <= status_next;
                both_reg      <= both_next;
                prev_reg      <= prev_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            out_rdata_reg <= rdata_next;
            out_pin_reg   <= data_next;
            out_oe_reg    <= dir_next;
            out_irq_reg   <= |(status_next & mask_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_irq_reg, out_oe_reg, out_pin_reg, out_rdata_reg};

    // status never holds bits of absent pins
    a_status_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg & ~PinMask) == '0)
        else $error("status bit set beyond pin count");

    // the reported irq matches the register state that its word left behind
    a_irq_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_irq_reg == (|(status_reg & mask_reg)))
        else $error("irq result disagrees with status and mask");

    // a status write can only clear bits
    a_status_w1c: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && req == REQ_WRITE && idx == REG_STATUS)
        |=> (status_reg & ~$past(status_reg)) == '0)
        else $error("status write set a bit");

    // every tick records the sampled levels
    a_prev_track: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && req == REQ_TICK) |=> prev_reg == $past(levels))
        else $error("previous levels not updated on tick");

    // state only moves when a word executes
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(status_reg) && $stable(data_reg) && $stable(prev_reg))
        else $error("port state changed without a word");

endmodule
